/* sv/twbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbt_pkg: shared types and constants of the two-wire byte transmitter
// Holds the pin-state record that passes from the sequencer to the output
// stage, and the byte geometry.
// ----------------------------------------------------------------------------
package twbt_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

  // one pin state on the two-wire bus
  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic data_driven;
    logic last_step;
  } pin_step_t;

endpackage

/* sv/twbt_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbt_seq: pin-state sequencer
// Holds the accepted byte and last driven data level; walks optional start,
// eight data bits, ack slot, optional stop; a pin state per unstalled cycle.
// ----------------------------------------------------------------------------
module twbt_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                send_start,
  input  logic                send_stop,
  output logic                step_valid,
  output twbt_pkg::pin_step_t step,
  input  logic                step_take
);
  import twbt_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_BITS, PH_ACK, PH_STOP} phase_t;

  logic                 busy;
  phase_t               phase;
  logic [1:0]           sub;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic [7:0]           shift;
  logic                 stop_flag;
  logic                 held;

  logic                 advance;
  logic                 accept;

  // build the pin state for the current position
  always_comb begin
    step = '0;
    case (phase)
      PH_START: begin
        step.data_driven = 1'b1;
        case (sub)
          2'd0:    begin step.clock_level = 1'b1; step.data_level = 1'b1; end
          2'd1:    begin step.clock_level = 1'b1; step.data_level = 1'b0; end
          default: begin step.clock_level = 1'b0; step.data_level = 1'b0; end
        endcase
      end
      PH_BITS: begin
        step.data_driven = 1'b1;
        case (sub)
          2'd0:    begin step.clock_level = 1'b0; step.data_level = held;     end
          2'd1:    begin step.clock_level = 1'b0; step.data_level = shift[0]; end
          default: begin step.clock_level = 1'b1; step.data_level = shift[0]; end
        endcase
      end
      PH_ACK: begin
        case (sub)
          2'd0:    step.clock_level = 1'b0;
          2'd1:    step.clock_level = 1'b1;
          default: begin
            step.clock_level = 1'b0;
            step.data_level  = held;
            step.data_driven = 1'b1;
            step.last_step   = ~stop_flag;
          end
        endcase
      end
      default: begin
        step.data_driven = 1'b1;
        case (sub)
          2'd0:    begin step.clock_level = 1'b0; step.data_level = 1'b0; end
          2'd1:    begin step.clock_level = 1'b1; step.data_level = 1'b0; end
          default: begin
            step.clock_level = 1'b1;
            step.data_level  = 1'b1;
            step.last_step   = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign step_valid = busy;
  assign advance    = busy & step_take;
  // take the next byte as the final pin state of this byte leaves
  assign in_stall   = busy & ~(advance & step.last_step);
  assign accept     = in_valid & ~in_stall;

  // hold the byte and advance through the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      phase   <= PH_START;
      sub     <= 2'd0;
      bit_idx <= '0;
      held    <= 1'b1;
    end else begin
      if (advance) begin
        if (step.data_driven) begin
          held <= step.data_level;
        end
        if (step.last_step) begin
          busy <= 1'b0;
        end
        if (sub == 2'd2) begin
          sub <= 2'd0;
          case (phase)
            PH_START: phase <= PH_BITS;
            PH_BITS: begin
              shift   <= shift >> 1;
              bit_idx <= bit_idx + 1'b1;
              if (bit_idx == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
                phase <= PH_ACK;
              end
            end
            PH_ACK:  phase <= PH_STOP;
            default: phase <= PH_STOP;
          endcase
        end else begin
          sub <= sub + 2'd1;
        end
      end
      if (accept) begin
        busy      <= 1'b1;
        phase     <= send_start ? PH_START : PH_BITS;
        sub       <= 2'd0;
        bit_idx   <= '0;
        shift     <= data_byte;
        stop_flag <= send_stop;
      end
    end
  end

endmodule

/* sv/twbt_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbt_out_reg: result register
// Registers one pin state per beat and holds it while the output stalls.
// ----------------------------------------------------------------------------
module twbt_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_valid,
  input  twbt_pkg::pin_step_t step,
  output logic                step_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                clock_level,
  output logic                data_level,
  output logic                data_driven,
  output logic                last_step
);
  import twbt_pkg::*;

  logic      full;
  pin_step_t held_step;

  // load when the register is empty or its beat leaves this cycle
  assign step_take = ~full | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (step_take) begin
      full <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_take && step_valid) begin
      held_step <= step;
    end
  end

  assign out_valid   = full;
  assign clock_level = held_step.clock_level;
  assign data_level  = held_step.data_level;
  assign data_driven = held_step.data_driven;
  assign last_step   = held_step.last_step;

endmodule

/* sv/two_wire_byte_transmitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_byte_transmitter: LSB-first two-wire byte writer with ack slot
// Turns one byte plus start/stop flags into the run of pin states of a
// bit-banged two-wire master, one pin state per output beat.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_stall | data_byte, send_start, send_stop
//   output  | out_valid/out_stall | clock_level, data_level, data_driven,
//           |                     | last_step
//
// A byte yields 27 to 33 output beats, one per cycle when not stalled: 24 for
// the data bits and 3 for the ack slot, plus 3 for each of start and stop.
// The next byte is taken in the cycle its predecessor's final pin state moves
// into the result register, so bytes follow with no gap.
// Reset sets the held data level to 1 (idle high) and empties both stages.
// An output stall holds a full result register and freezes the sequencer.
// ----------------------------------------------------------------------------
module two_wire_byte_transmitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       send_start,
  input  logic       send_stop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       clock_level,
  output logic       data_level,
  output logic       data_driven,
  output logic       last_step
);
  import twbt_pkg::*;

  logic      step_valid;
  logic      step_take;
  pin_step_t step;

  // walk the pin-state sequence of each byte
  twbt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .send_start (send_start),
    .send_stop  (send_stop),
    .step_valid (step_valid),
    .step       (step),
    .step_take  (step_take)
  );

  // register each beat toward the output
  twbt_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .step_valid  (step_valid),
    .step        (step),
    .step_take   (step_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .clock_level (clock_level),
    .data_level  (data_level),
    .data_driven (data_driven),
    .last_step   (last_step)
  );

endmodule

/* tb/two_wire_byte_transmitter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_byte_transmitter_tb: self-checking bench for the two-wire writer
// Feeds bytes with start/stop flags and checks every output beat against a
// predicted run of pin states. The input and output sides idle and stall in
// random bursts. The last part of the run has no idling.
// ----------------------------------------------------------------------------
module two_wire_byte_transmitter_tb;
  import twbt_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_BYTES    = 500;
  localparam int CALM_TAIL       = 60;
  localparam int MAX_REPORTS     = 100;

  // Predicts the pin states of each byte and checks the output beats.
  class pin_sequence_board;
    pin_step_t pending_pins[$];
    logic      line_level;
    int        errors;
    int        beats_seen;

    function new();
      line_level = 1'b1;
      errors     = 0;
      beats_seen = 0;
    endfunction

    // queue one pin state; a driven data pin updates the held level
    function void push_pin(logic clk_lvl, logic dat, logic drv);
      pin_step_t s;
      s.clock_level = clk_lvl;
      s.data_level  = drv ? dat : 1'b0;
      s.data_driven = drv;
      s.last_step   = 1'b0;
      if (drv) begin
        line_level = dat;
      end
      pending_pins.push_back(s);
    endfunction

    // expand one accepted byte into its pin states
    function void note_byte(logic [7:0] b, logic st, logic sp);
      pin_step_t tail;
      logic [7:0] shifter;
      shifter = b;
      if (st) begin
        push_pin(1'b1, 1'b1, 1'b1);
        push_pin(1'b1, 1'b0, 1'b1);
        push_pin(1'b0, 1'b0, 1'b1);
      end
      for (int i = 0; i < BITS_PER_BYTE; i++) begin
        push_pin(1'b0, line_level, 1'b1);
        push_pin(1'b0, shifter[0], 1'b1);
        push_pin(1'b1, shifter[0], 1'b1);
        shifter = shifter >> 1;
      end
      // ack slot: release, clock high, drive the held level again
      push_pin(1'b0, 1'b0, 1'b0);
      push_pin(1'b1, 1'b0, 1'b0);
      push_pin(1'b0, line_level, 1'b1);
      if (sp) begin
        push_pin(1'b0, 1'b0, 1'b1);
        push_pin(1'b1, 1'b0, 1'b1);
        push_pin(1'b1, 1'b1, 1'b1);
      end
      tail = pending_pins.pop_back();
      tail.last_step = 1'b1;
      pending_pins.push_back(tail);
    endfunction

    // print one line per mismatch, up to a cap, and count them all
    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endtask

    task check_beat(pin_step_t got);
      pin_step_t want;
      beats_seen++;
      if (pending_pins.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected (%b)", beats_seen, got));
      end else begin
        want = pending_pins.pop_front();
        if (got.clock_level !== want.clock_level)
          report($sformatf("beat %0d clock_level %b want %b", beats_seen,
                           got.clock_level, want.clock_level));
        if (got.data_level !== want.data_level)
          report($sformatf("beat %0d data_level %b want %b", beats_seen,
                           got.data_level, want.data_level));
        if (got.data_driven !== want.data_driven)
          report($sformatf("beat %0d data_driven %b want %b", beats_seen,
                           got.data_driven, want.data_driven));
        if (got.last_step !== want.last_step)
          report($sformatf("beat %0d last_step %b want %b", beats_seen,
                           got.last_step, want.last_step));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       send_start = 1'b0;
  logic       send_stop = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       clock_level;
  logic       data_level;
  logic       data_driven;
  logic       last_step;

  pin_sequence_board board = new();
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  two_wire_byte_transmitter DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .send_start  (send_start),
    .send_stop   (send_stop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .clock_level (clock_level),
    .data_level  (data_level),
    .data_driven (data_driven),
    .last_step   (last_step)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // note accepted bytes first, then check output beats of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        board.note_byte(data_byte, send_start, send_stop);
      if (out_valid && !out_stall)
        board.check_beat({clock_level, data_level, data_driven, last_step});
    end
  end

  // stall the output side in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_stall  <= 1'b1;
    end
  end

  // end the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte, after an optional random gap, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic st, input logic sp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    send_start <= st;
    send_stop  <= sp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the input until every predicted pin state has come out
  task automatic drain_pins();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_pins.size() != 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // first byte after reset with no start sees the idle-high level
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    // no start right after a stop: the held level is high
    send_byte(8'h80, 1'b0, 1'b0);
    // no start after an ack slot: the held level is the previous top bit
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b1);
    send_byte(8'h3C, 1'b0, 1'b0);

    for (int i = 0; i < RANDOM_BYTES; i++) begin
      // switch idling on and off in stretches; none in the tail
      if (i % 50 == 0)
        idle_on = (i < RANDOM_BYTES - CALM_TAIL) ? ($urandom_range(0, 3) != 0) : 1'b0;
      if (i == RANDOM_BYTES / 2)
        drain_pins();
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    idle_on = 1'b0;

    drain_pins();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_pins.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
